FILE: rtl/core/e2c_pkg.sv
// e2c_pkg: shared types, constants and the month length table
// for the epoch to calendar date unit; no dependencies
`timescale 1ns / 1ps

package e2c_pkg;

    localparam int unsigned EPOCH_W = 33;
    localparam int unsigned OFFSET_W = 17;
    localparam int unsigned WIDE_W = 35;
    localparam int unsigned ACC_W = 33;
    localparam int unsigned BASE_W = 17;
    localparam int unsigned SHIFT_W = 5;
    localparam int unsigned IN_DATA_W = 40;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [WIDE_W-1:0] C_SECS_AT_1900 = 35'd2208988800;
    localparam logic [WIDE_W-1:0] C_SPAN_SECS = 35'd6311433600;
    localparam logic [BASE_W-1:0] C_SECS_PER_DAY = 17'd86400;
    localparam logic [BASE_W-1:0] C_SECS_PER_HOUR = 17'd3600;
    localparam logic [BASE_W-1:0] C_SECS_PER_MIN = 17'd60;
    localparam logic [BASE_W-1:0] C_DAYS_PER_WEEK = 17'd7;
    localparam logic [BASE_W-1:0] C_DAYS_YEAR = 17'd365;
    localparam logic [BASE_W-1:0] C_DAYS_LEAP_YEAR = 17'd366;
    localparam logic [7:0] C_LAST_YEAR_IDX = 8'd199;
    localparam logic [3:0] C_LAST_MONTH = 4'd11;
    localparam logic [3:0] C_FEBRUARY = 4'd1;

    localparam logic [SHIFT_W-1:0] C_DAYS_TOP_BIT = 5'd16;
    localparam logic [SHIFT_W-1:0] C_HOURS_TOP_BIT = 5'd4;
    localparam logic [SHIFT_W-1:0] C_MINS_TOP_BIT = 5'd5;
    localparam logic [SHIFT_W-1:0] C_WDAY_TOP_BIT = 5'd14;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DAYS,
        ST_HOURS,
        ST_MINS,
        ST_SEC_LOAD,
        ST_WDAY,
        ST_YEAR_LOAD,
        ST_YEARS,
        ST_MONTHS,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [SHIFT_W-1:0] shift;
    } t_unit_req;

    typedef struct packed {
        logic             ge;
        logic [ACC_W-1:0] diff;
    } t_unit_rsp;

    function automatic logic [BASE_W-1:0] month_len(input logic [3:0] month,
                                                   input logic leap);
        logic [BASE_W-1:0] len;
        case (month)
            4'd0:    len = 17'd31;
            4'd1:    len = leap ? 17'd29 : 17'd28;
            4'd2:    len = 17'd31;
            4'd3:    len = 17'd30;
            4'd4:    len = 17'd31;
            4'd5:    len = 17'd30;
            4'd6:    len = 17'd31;
            4'd7:    len = 17'd31;
            4'd8:    len = 17'd30;
            4'd9:    len = 17'd31;
            4'd10:   len = 17'd30;
            4'd11:   len = 17'd31;
            default: len = 17'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/e2c_cmp_sub.sv
// e2c_cmp_sub: shared shift, compare and subtract unit
// depends on e2c_pkg for the request and response types
`timescale 1ns / 1ps

module e2c_cmp_sub (
    input  logic [e2c_pkg::ACC_W-1:0] i_acc,
    input  e2c_pkg::t_unit_req        i_req,
    output e2c_pkg::t_unit_rsp        o_rsp
);
    import e2c_pkg::*;

    logic [ACC_W-1:0] operand;
    logic [ACC_W:0]   diff;

    assign operand = ACC_W'(i_req.base) << i_req.shift;
    assign diff = {1'b0, i_acc} - {1'b0, operand};

    assign o_rsp.ge = ~diff[ACC_W];
    assign o_rsp.diff = diff[ACC_W-1:0];

endmodule

FILE: rtl/core/epoch_to_calendar_date_unit.sv
// epoch_to_calendar_date_unit: top level, sequencer around the shared unit
// depends on e2c_pkg and e2c_cmp_sub
`timescale 1ns / 1ps

// Converts signed epoch seconds plus the programmed zone offset into a civil
// date and time for 1900 through 2099. One item is worked on at a time and
// s_axis_tready is low while it runs. An item outside the span goes from the
// range check straight to the finish state, with tuser low and all fields
// zero. The single compare-subtract unit does one step a cycle: 17 steps for
// days, 5 for hours, 6 for minutes, 15 for the weekday, then one step per
// year of the year index (0..199) and per month of the month index (0..11).
// A new item is taken while the last result still waits in the output
// register. Zone offset writes are taken at any time and should come only
// while the unit is idle.

module epoch_to_calendar_date_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [e2c_pkg::OFFSET_W-1:0]       i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // epoch_seconds[32:0], zero fill [39:33]
    input  logic [e2c_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // years_since_1900[7:0], month_index[11:8], day_of_month[16:12],
    // hour_of_day[21:17], minute_of_hour[27:22], second_of_minute[33:28],
    // weekday[36:34], day_of_year[45:37], zero fill [47:46]
    output logic [e2c_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // valid_res[0]
    output logic                               m_axis_tuser
);
    import e2c_pkg::*;

    t_state r_state, n_state;

    logic [OFFSET_W-1:0]   r_offset;
    logic [WIDE_W-1:0]     r_u, n_u;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [SHIFT_W-1:0]    r_k, n_k;
    logic                  r_in_span, n_in_span;
    logic [16:0]           r_days, n_days;
    logic [4:0]            r_hour, n_hour;
    logic [5:0]            r_min, n_min;
    logic [5:0]            r_sec, n_sec;
    logic [2:0]            r_wday, n_wday;
    logic [7:0]            r_year, n_year;
    logic [8:0]            r_doy, n_doy;
    logic [3:0]            r_month, n_month;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                  r_out_user, n_out_user;

    logic       in_accept;
    logic       out_free;
    logic       out_of_span;
    logic       leap;
    logic       k_last;
    logic       year_step;
    logic       month_step;
    logic [4:0] day_out;
    t_unit_req  unit_req;
    t_unit_rsp  unit_rsp;

    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign out_free = ~r_out_valid | m_axis_tready;
    assign out_of_span = r_u[WIDE_W-1] | (r_u >= C_SPAN_SECS);
    assign leap = (r_year[1:0] == 2'b00) & (r_year != 8'd0);
    assign k_last = (r_k == '0);
    assign year_step = unit_rsp.ge & (r_year != C_LAST_YEAR_IDX);
    assign month_step = unit_rsp.ge & (r_month != C_LAST_MONTH);
    assign day_out = r_acc[4:0] + 5'd1;

    e2c_cmp_sub u_cmp_sub (
        .i_acc (r_acc),
        .i_req (unit_req),
        .o_rsp (unit_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (in_accept) n_state = ST_CHECK;
            ST_CHECK:     n_state = out_of_span ? ST_FINISH : ST_DAYS;
            ST_DAYS:      if (k_last) n_state = ST_HOURS;
            ST_HOURS:     if (k_last) n_state = ST_MINS;
            ST_MINS:      if (k_last) n_state = ST_SEC_LOAD;
            ST_SEC_LOAD:  n_state = ST_WDAY;
            ST_WDAY:      if (k_last) n_state = ST_YEAR_LOAD;
            ST_YEAR_LOAD: n_state = ST_YEARS;
            ST_YEARS:     if (!year_step) n_state = ST_MONTHS;
            ST_MONTHS:    if (!month_step) n_state = ST_FINISH;
            ST_FINISH:    if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // shared unit operand select
    always_comb begin
        unit_req.base = '0;
        unit_req.shift = r_k;
        unique case (r_state)
            ST_DAYS:   unit_req.base = C_SECS_PER_DAY;
            ST_HOURS:  unit_req.base = C_SECS_PER_HOUR;
            ST_MINS:   unit_req.base = C_SECS_PER_MIN;
            ST_WDAY:   unit_req.base = C_DAYS_PER_WEEK;
            ST_YEARS: begin
                unit_req.base = leap ? C_DAYS_LEAP_YEAR : C_DAYS_YEAR;
                unit_req.shift = '0;
            end
            ST_MONTHS: begin
                unit_req.base = month_len(r_month, leap);
                unit_req.shift = '0;
            end
            default: begin
                unit_req.base = '0;
                unit_req.shift = '0;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_u = r_u;
        n_acc = r_acc;
        n_k = r_k - 5'd1;
        n_in_span = r_in_span;
        n_days = r_days;
        n_hour = r_hour;
        n_min = r_min;
        n_sec = r_sec;
        n_wday = r_wday;
        n_year = r_year;
        n_doy = r_doy;
        n_month = r_month;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_data = r_out_data;
        n_out_user = r_out_user;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_u = {{(WIDE_W-EPOCH_W){s_axis_tdata[EPOCH_W-1]}},
                           s_axis_tdata[EPOCH_W-1:0]}
                        + {{(WIDE_W-OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset}
                        + C_SECS_AT_1900;
                end
            end
            ST_CHECK: begin
                n_in_span = ~out_of_span;
                n_acc = r_u[ACC_W-1:0];
                n_k = C_DAYS_TOP_BIT;
            end
            ST_DAYS: begin
                if (unit_rsp.ge) n_acc = unit_rsp.diff;
                n_days = {r_days[15:0], unit_rsp.ge};
                if (k_last) n_k = C_HOURS_TOP_BIT;
            end
            ST_HOURS: begin
                if (unit_rsp.ge) n_acc = unit_rsp.diff;
                n_hour = {r_hour[3:0], unit_rsp.ge};
                if (k_last) n_k = C_MINS_TOP_BIT;
            end
            ST_MINS: begin
                if (unit_rsp.ge) n_acc = unit_rsp.diff;
                n_min = {r_min[4:0], unit_rsp.ge};
            end
            ST_SEC_LOAD: begin
                n_sec = r_acc[5:0];
                n_acc = {{(ACC_W-17){1'b0}}, r_days} + ACC_W'(1);
                n_k = C_WDAY_TOP_BIT;
            end
            ST_WDAY: begin
                if (unit_rsp.ge) n_acc = unit_rsp.diff;
            end
            ST_YEAR_LOAD: begin
                n_wday = r_acc[2:0];
                n_acc = {{(ACC_W-17){1'b0}}, r_days};
                n_year = '0;
            end
            ST_YEARS: begin
                if (year_step) begin
                    n_acc = unit_rsp.diff;
                    n_year = r_year + 8'd1;
                end else begin
                    n_doy = r_acc[8:0];
                    n_month = '0;
                end
            end
            ST_MONTHS: begin
                if (month_step) begin
                    n_acc = unit_rsp.diff;
                    n_month = r_month + 4'd1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user = r_in_span;
                    if (r_in_span) begin
                        n_out_data = {2'b00, r_doy, r_wday, r_sec, r_min, r_hour,
                                      day_out, r_month, r_year};
                    end else begin
                        n_out_data = '0;
                    end
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_offset <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_offset <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        r_acc <= n_acc;
        r_k <= n_k;
        r_in_span <= n_in_span;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min <= n_min;
        r_sec <= n_sec;
        r_wday <= n_wday;
        r_year <= n_year;
        r_doy <= n_doy;
        r_month <= n_month;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_user;

endmodule

FILE: rtl/core/e2c_checker.sv
// e2c_checker: port level assertions for epoch_to_calendar_date_unit
// depends on e2c_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module e2c_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [e2c_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);
    import e2c_pkg::*;

    // one item in flight: input side closes after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready after item accepted");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result item changed");

    // out of span items carry all zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("out of span item with nonzero fields");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[7:0] <= 8'd199 && m_axis_tdata[11:8] <= 4'd11
            && m_axis_tdata[16:12] != 5'd0 && m_axis_tdata[21:17] <= 5'd23
            && m_axis_tdata[27:22] <= 6'd59 && m_axis_tdata[33:28] <= 6'd59
            && m_axis_tdata[36:34] <= 3'd6 && m_axis_tdata[45:37] <= 9'd365
            && m_axis_tdata[47:46] == 2'b00)
        else $error("result field out of range");

endmodule

bind epoch_to_calendar_date_unit e2c_checker u_e2c_checker (.*);

FILE: verif/epoch_to_calendar_date_unit_test.sv
// epoch_to_calendar_date_unit_test: self-checking bench for the epoch to calendar date unit
// drives epoch items and zone offsets, predicts each calendar result and compares field by field
// depends on e2c_pkg and the epoch_to_calendar_date_unit rtl
`timescale 1ns / 1ps

module epoch_to_calendar_date_unit_test;
    import e2c_pkg::*;

    localparam longint SECS_1900 = -64'sd2208988800;
    localparam longint SECS_2100 = 64'sd4102444800;
    localparam longint DAY_SECS = 64'sd86400;
    localparam int DAYS_IN_SPAN = 73049;
    localparam int PHASES = 5;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int DRAIN_CYCLES = 300;

    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int FIELD_LO [9] = '{0, 8, 12, 17, 22, 28, 34, 37, 46};
    localparam int FIELD_W [9] = '{8, 4, 5, 5, 6, 6, 3, 9, 2};
    string FIELD_NAMES [9] = '{"years_since_1900", "month_index", "day_of_month",
        "hour_of_day", "minute_of_hour", "second_of_minute", "weekday", "day_of_year",
        "zero fill"};

    typedef struct packed {
        logic                  ok;
        logic [OUT_DATA_W-1:0] fields;
    } civil_date_t;

    typedef struct packed {
        logic                set_zone;
        logic [OFFSET_W-1:0] zone;
        logic [EPOCH_W-1:0]  epoch;
        logic                typed;
        logic                ok;
        logic [7:0]          yr;
        logic [3:0]          mo;
        logic [4:0]          dy;
        logic [4:0]          hr;
        logic [5:0]          mi;
        logic [5:0]          se;
        logic [2:0]          wd;
        logic [8:0]          yd;
    } directed_row_t;

    // set_zone, zone, epoch, typed, ok, year, month, day, hour, min, sec, wday, yday
    localparam directed_row_t DIRECTED_ROWS [25] = '{
        '{0, 0, 0, 1, 1, 70, 0, 1, 0, 0, 0, 4, 0},
        '{0, 0, -33'sd1, 1, 1, 69, 11, 31, 23, 59, 59, 3, 364},
        '{0, 0, -33'sd2208988800, 1, 1, 0, 0, 1, 0, 0, 0, 1, 0},
        '{0, 0, -33'sd2208988801, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 33'd4102444799, 1, 1, 199, 11, 31, 23, 59, 59, 4, 364},
        '{0, 0, 33'd4102444800, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 33'h0FFFFFFFF, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 33'h100000000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 33'd951782400, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, -33'sd2203891200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, -33'sd2203977600, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 33'd4007836799, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 33'd946684799, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 33'd1234567890, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 17'd50400, 33'd4102394399, 1, 1, 199, 11, 31, 23, 59, 59, 4, 364},
        '{0, 0, 33'd4102394400, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, -33'sd2208988800, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, -17'sd50400, -33'sd2208988800, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, -33'sd2208938400, 1, 1, 0, 0, 1, 0, 0, 0, 1, 0},
        '{0, 0, 33'd4102444799, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 17'h0FFFF, 33'd4102379264, 1, 1, 199, 11, 31, 23, 59, 59, 4, 364},
        '{0, 0, 33'd4102379265, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 17'h10000, -33'sd2208923264, 1, 1, 0, 0, 1, 0, 0, 0, 1, 0},
        '{0, 0, -33'sd2208923265, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 33'h0FFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [OFFSET_W-1:0]   i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // epoch_seconds[32:0], zero fill [39:33]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // years_since_1900[7:0], month_index[11:8], day_of_month[16:12],
    // hour_of_day[21:17], minute_of_hour[27:22], second_of_minute[33:28],
    // weekday[36:34], day_of_year[45:37], zero fill [47:46]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // valid_res[0]
    logic                  m_axis_tuser;

    logic [OFFSET_W-1:0]   zone_setting = '0;
    civil_date_t           dates_pending [$];
    int                    mismatches = 0;
    int                    send_calm = 0;
    int                    recv_calm = 0;

    epoch_to_calendar_date_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic is_leap(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [OUT_DATA_W-1:0] pack_date(int yr, int mo, int dy, int hr,
                                                        int mi, int se, int wd, int yd);
        return {2'b00, 9'(yd), 3'(wd), 6'(se), 6'(mi), 5'(hr), 5'(dy), 4'(mo), 8'(yr)};
    endfunction

    function automatic civil_date_t civil_date_of(logic signed [EPOCH_W-1:0] secs,
                                                  logic signed [OFFSET_W-1:0] zone);
        longint      t;
        longint      u;
        int          days;
        int          sod;
        int          rest;
        int          yr;
        int          yd;
        int          mo;
        int          mlen;
        civil_date_t r;
        t = longint'(secs) + longint'(zone);
        r = '0;
        if (t < SECS_1900 || t >= SECS_2100) begin
            return r;
        end
        u = t - SECS_1900;
        days = int'(u / DAY_SECS);
        sod = int'(u % DAY_SECS);
        rest = days;
        yr = 0;
        while (yr < 199 && rest >= (is_leap(1900 + yr) ? 366 : 365)) begin
            rest -= is_leap(1900 + yr) ? 366 : 365;
            yr++;
        end
        yd = rest;
        mo = 0;
        mlen = MONTH_DAYS[0];
        while (mo < 11 && rest >= mlen) begin
            rest -= mlen;
            mo++;
            mlen = MONTH_DAYS[mo] + ((mo == 1 && is_leap(1900 + yr)) ? 1 : 0);
        end
        r.ok = 1'b1;
        r.fields = pack_date(yr, mo, rest + 1, sod / 3600, (sod % 3600) / 60, sod % 60,
                             (days + 1) % 7, yd);
        return r;
    endfunction

    // mostly in-span times, some near span edges and year or leap-day midnights, some raw bits
    function automatic logic [EPOCH_W-1:0] pick_epoch(logic signed [OFFSET_W-1:0] zone);
        longint secs;
        int     pick;
        int     y;
        int     day;
        pick = int'($urandom_range(0, 99));
        if (pick < 12) begin
            return {$urandom_range(0, 1) == 1, $urandom()};
        end
        if (pick < 25) begin
            secs = (pick < 19 ? SECS_1900 : SECS_2100) + longint'(int'($urandom_range(0, 200)))
                   - 100;
        end else if (pick < 45) begin
            y = int'($urandom_range(1900, 2099));
            day = 365 * (y - 1900) + ((y - 1) / 4 - 475) - ((y - 1) / 100 - 19)
                  + ((y - 1) / 400 - 4);
            day += ($urandom_range(0, 1) == 1 ? 59 : 0) + int'($urandom_range(0, 2)) - 1;
            secs = SECS_1900 + DAY_SECS * longint'(day) + longint'(int'($urandom_range(0, 6)))
                   - 3;
        end else begin
            secs = SECS_1900 + DAY_SECS * longint'(int'($urandom_range(0, DAYS_IN_SPAN - 1)))
                   + longint'(int'($urandom_range(0, 86399)));
        end
        return EPOCH_W'(secs - longint'(zone));
    endfunction

    // wait in cycles before the next item, with occasional runs of back-to-back items
    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm = int'($urandom_range(8, 40));
            return 0;
        end
        return int'($urandom_range(0, 12));
    endfunction

    task automatic send_epoch(logic [EPOCH_W-1:0] secs, logic typed, civil_date_t typed_date);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - EPOCH_W){1'b0}}, secs};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        dates_pending.push_back(typed ? typed_date : civil_date_of(secs, zone_setting));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (dates_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_zone(logic [OFFSET_W-1:0] zone);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= zone;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        zone_setting = zone;
    endtask

    task automatic check_date(logic [OUT_DATA_W-1:0] got_fields, logic got_ok);
        civil_date_t           want;
        logic [OUT_DATA_W-1:0] w;
        logic [OUT_DATA_W-1:0] g;
        if (dates_pending.size() == 0) begin
            $display("%0t: unexpected item: expected none, got valid_res %0b fields %h",
                     $time, got_ok, got_fields);
            mismatches++;
            return;
        end
        want = dates_pending.pop_front();
        if (want.ok !== got_ok) begin
            $display("%0t: valid_res expected %0b got %0b", $time, want.ok, got_ok);
            mismatches++;
        end
        for (int i = 0; i < 9; i++) begin
            w = (want.fields >> FIELD_LO[i]) & ~({OUT_DATA_W{1'b1}} << FIELD_W[i]);
            g = (got_fields >> FIELD_LO[i]) & ~({OUT_DATA_W{1'b1}} << FIELD_W[i]);
            if (w !== g) begin
                $display("%0t: %s expected %0d got %0d", $time, FIELD_NAMES[i], w, g);
                mismatches++;
            end
        end
    endtask

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            check_date(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        civil_date_t         typed_date;
        logic [OFFSET_W-1:0] zone_pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[k]) begin
            if (DIRECTED_ROWS[k].set_zone) begin
                drain_results();
                write_zone(DIRECTED_ROWS[k].zone);
            end
            typed_date.ok = DIRECTED_ROWS[k].ok;
            typed_date.fields = pack_date(DIRECTED_ROWS[k].yr, DIRECTED_ROWS[k].mo,
                DIRECTED_ROWS[k].dy, DIRECTED_ROWS[k].hr, DIRECTED_ROWS[k].mi,
                DIRECTED_ROWS[k].se, DIRECTED_ROWS[k].wd, DIRECTED_ROWS[k].yd);
            send_epoch(DIRECTED_ROWS[k].epoch, DIRECTED_ROWS[k].typed, typed_date);
        end

        // zone extremes, a legal random zone, raw 17-bit zone, back to zero
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    zone_pick = 17'd50400;
                end
                1: begin
                    zone_pick = -17'sd50400;
                end
                2: begin
                    zone_pick = OFFSET_W'($urandom_range(0, 100800) - 50400);
                end
                3: begin
                    zone_pick = OFFSET_W'($urandom());
                end
                default: begin
                    zone_pick = '0;
                end
            endcase
            write_zone(zone_pick);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_epoch(pick_epoch(zone_setting), 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
